FILE: src/abmc_pkg.sv
// Package of the batch motion classifier: widths, codes and shared types.
`timescale 1ns / 1ps

package abmc_pkg;

  localparam int RAW_W      = 16;
  localparam int SHIFT_BITS = 4;
  localparam int AXIS_W     = RAW_W - SHIFT_BITS;
  localparam int DIFF_W     = AXIS_W + 1;
  localparam int THR_W      = 12;
  localparam int WIN_W      = 13;
  localparam int CNT_W      = 7;
  localparam int AXES       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam int SETS_PER_BATCH_DEF = 32;

  localparam logic [THR_W-1:0]        MOTION_THRESHOLD_RST = 12'd300;
  localparam logic signed [WIN_W-1:0] STILL_LOW_RST        = -13'sd100;
  localparam logic signed [WIN_W-1:0] STILL_HIGH_RST       = 13'sd100;
  localparam logic [CNT_W-1:0]        STILL_NEEDED_RST     = 7'd93;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    VERDICT_MOTION  = 2'd0,
    VERDICT_STILL   = 2'd1,
    VERDICT_RECHECK = 2'd2
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOTION_THRESHOLD = 2'd0,
    CFG_STILL_LOW        = 2'd1,
    CFG_STILL_HIGH       = 2'd2,
    CFG_STILL_NEEDED     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic motion;
    logic still;
  } judge_t;

endpackage

FILE: src/abmc_if.sv
// Stream interfaces for sample set words and verdict words.
`timescale 1ns / 1ps

interface abmc_in_if import abmc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [RAW_W-1:0] x_raw;
  logic signed [RAW_W-1:0] y_raw;
  logic signed [RAW_W-1:0] z_raw;

  modport source (output valid, output op, output x_raw, output y_raw, output z_raw,
                  input ready);
  modport sink (input valid, input op, input x_raw, input y_raw, input z_raw,
                output ready);
endinterface

interface abmc_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink (input valid, input verdict, output ready);
endinterface

FILE: src/accel_batch_motion_classifier.sv
// Top level of the batch motion classifier.
`timescale 1ns / 1ps
// Usage: sample set words arrive on in_ch (op, x_raw, y_raw, z_raw); a word
// with op clear starts a new session and gives no verdict. A word with op set
// is a sample set; after SETS_PER_BATCH sets one verdict word leaves on out_ch.
// Each word is taken into an input register, judged on all three axes in one
// pass against the previous set, and the verdict is placed in an output
// register. One word is accepted in every cycle while the receiver takes
// verdicts; the figure is set by the single judging stage between the two
// registers. When the receiver stalls, the verdict is held and one further
// word may still be taken into the input register before in_ch.ready falls.
// Registers are to be written through cfg_we, cfg_index and cfg_wdata only
// while idle; the block itself does not enforce this. Reset clears the
// session, the batch state, the previous axis values and the valid flags of
// both registers, and restores the register defaults.

module accel_batch_motion_classifier import abmc_pkg::*; #(
  parameter int SETS_PER_BATCH = SETS_PER_BATCH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  abmc_in_if.sink               in_ch,
  abmc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(SETS_PER_BATCH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SETS_PER_BATCH - 1);

  logic [THR_W-1:0]        motion_threshold_r;
  logic signed [WIN_W-1:0] still_low_r;
  logic signed [WIN_W-1:0] still_high_r;
  logic [CNT_W-1:0]        still_needed_r;

  logic                     s1_valid_r;
  op_t                      s1_op_r;
  logic signed [AXIS_W-1:0] s1_x_r, s1_y_r, s1_z_r;

  logic signed [AXIS_W-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic [IDX_W-1:0]         set_index_r, set_index_nxt;
  logic [CNT_W-1:0]         still_count_r, still_count_nxt;
  logic                     motion_seen_r, motion_seen_nxt;
  logic                     checked_once_r, checked_once_nxt;

  logic     out_valid_r;
  verdict_t verdict_r, verdict_nxt;

  logic   advance, s1_fire, produce;
  judge_t jx, jy, jz;
  logic   judging, motion_any;
  logic [1:0]       n_still;
  logic [CNT_W+1:0] count_sum;

  abmc_axis_judge u_judge_x (.cur(s1_x_r), .prev(prev_x_r), .thr(motion_threshold_r),
    .still_low(still_low_r), .still_high(still_high_r), .res(jx));
  abmc_axis_judge u_judge_y (.cur(s1_y_r), .prev(prev_y_r), .thr(motion_threshold_r),
    .still_low(still_low_r), .still_high(still_high_r), .res(jy));
  abmc_axis_judge u_judge_z (.cur(s1_z_r), .prev(prev_z_r), .thr(motion_threshold_r),
    .still_low(still_low_r), .still_high(still_high_r), .res(jz));

  assign advance      = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && advance;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.verdict = verdict_r;

  always_comb begin
    judging = set_index_r != '0;
    motion_any = motion_seen_r || (judging && (jx.motion || jy.motion || jz.motion));
    n_still = judging ? (2'(jx.still) + 2'(jy.still) + 2'(jz.still)) : 2'd0;
    count_sum = (CNT_W+2)'(still_count_r) + (CNT_W+2)'(n_still);
    produce = (s1_op_r == OP_SAMPLE) && (set_index_r == LAST_IDX);

    set_index_nxt = set_index_r;
    still_count_nxt = still_count_r;
    motion_seen_nxt = motion_seen_r;
    checked_once_nxt = checked_once_r;
    verdict_nxt = VERDICT_MOTION;

    if (count_sum > (CNT_W+2)'(COUNT_MAX)) begin
      still_count_nxt = COUNT_MAX;
    end else begin
      still_count_nxt = count_sum[CNT_W-1:0];
    end

    if (motion_any) begin
      verdict_nxt = VERDICT_MOTION;
    end else if (still_count_nxt >= still_needed_r) begin
      verdict_nxt = VERDICT_STILL;
    end else if (checked_once_r) begin
      verdict_nxt = VERDICT_STILL;
    end else begin
      verdict_nxt = VERDICT_RECHECK;
    end

    if (s1_op_r == OP_START) begin
      set_index_nxt = '0;
      still_count_nxt = '0;
      motion_seen_nxt = 1'b0;
      checked_once_nxt = 1'b0;
    end else if (produce) begin
      set_index_nxt = '0;
      still_count_nxt = '0;
      motion_seen_nxt = 1'b0;
      checked_once_nxt = 1'b1;
    end else begin
      set_index_nxt = set_index_r + IDX_W'(1);
      motion_seen_nxt = motion_any;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_threshold_r <= MOTION_THRESHOLD_RST;
      still_low_r <= STILL_LOW_RST;
      still_high_r <= STILL_HIGH_RST;
      still_needed_r <= STILL_NEEDED_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MOTION_THRESHOLD: motion_threshold_r <= cfg_wdata[THR_W-1:0];
        CFG_STILL_LOW: still_low_r <= cfg_wdata[WIN_W-1:0];
        CFG_STILL_HIGH: still_high_r <= cfg_wdata[WIN_W-1:0];
        CFG_STILL_NEEDED: still_needed_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r <= op_t'(in_ch.op);
      s1_x_r <= in_ch.x_raw[RAW_W-1:SHIFT_BITS];
      s1_y_r <= in_ch.y_raw[RAW_W-1:SHIFT_BITS];
      s1_z_r <= in_ch.z_raw[RAW_W-1:SHIFT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      prev_z_r <= '0;
      set_index_r <= '0;
      still_count_r <= '0;
      motion_seen_r <= 1'b0;
      checked_once_r <= 1'b0;
    end else if (s1_fire) begin
      if (s1_op_r == OP_SAMPLE) begin
        prev_x_r <= s1_x_r;
        prev_y_r <= s1_y_r;
        prev_z_r <= s1_z_r;
      end
      set_index_r <= set_index_nxt;
      still_count_r <= still_count_nxt;
      motion_seen_r <= motion_seen_nxt;
      checked_once_r <= checked_once_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && produce) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && produce) begin
      verdict_r <= verdict_nxt;
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_op_r == OP_START) |=> (!checked_once_r && set_index_r == '0))
    else $error("start word did not clear the session state");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    set_index_r <= LAST_IDX)
    else $error("set index beyond the batch length");

  a_recheck_once: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && produce && verdict_nxt == VERDICT_RECHECK) |-> !checked_once_r)
    else $error("recheck requested twice in one session");

  a_batch_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && produce) |=> (set_index_r == '0 && still_count_r == '0 && !motion_seen_r
      && checked_once_r && out_valid_r))
    else $error("batch state not cleared after a verdict");

endmodule

FILE: src/abmc_axis_judge.sv
// Per-axis difference with motion and still window tests.
`timescale 1ns / 1ps

module abmc_axis_judge import abmc_pkg::*; (
  input  logic signed [AXIS_W-1:0] cur,
  input  logic signed [AXIS_W-1:0] prev,
  input  logic [THR_W-1:0]         thr,
  input  logic signed [WIN_W-1:0]  still_low,
  input  logic signed [WIN_W-1:0]  still_high,
  output judge_t                   res
);

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;

  always_comb begin
    diff = DIFF_W'(cur) - DIFF_W'(prev);
    mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    res.motion = mag > {1'b0, thr};
    res.still = (diff >= still_low) && (diff <= still_high);
  end

endmodule
